@@ src/cpu6502_pkg.sv @@
// Shared types, codes and constants for the 6502-style execution unit.
`default_nettype none
package cpu6502_pkg;

  typedef enum logic [5:0] {
    ACT_ADC     = 6'd0,
    ACT_AND     = 6'd1,
    ACT_ASL     = 6'd2,
    ACT_BIT     = 6'd3,
    ACT_CLC     = 6'd4,
    ACT_CLD     = 6'd5,
    ACT_CLI     = 6'd6,
    ACT_CLV     = 6'd7,
    ACT_CMP     = 6'd8,
    ACT_CPX     = 6'd9,
    ACT_CPY     = 6'd10,
    ACT_DEC     = 6'd11,
    ACT_DEX     = 6'd12,
    ACT_DEY     = 6'd13,
    ACT_EOR     = 6'd14,
    ACT_INC     = 6'd15,
    ACT_INX     = 6'd16,
    ACT_INY     = 6'd17,
    ACT_LDA     = 6'd18,
    ACT_LDX     = 6'd19,
    ACT_LDY     = 6'd20,
    ACT_LSR     = 6'd21,
    ACT_ORA     = 6'd22,
    ACT_PHA     = 6'd23,
    ACT_PHP     = 6'd24,
    ACT_PLA     = 6'd25,
    ACT_PLP     = 6'd26,
    ACT_ROL     = 6'd27,
    ACT_ROR     = 6'd28,
    ACT_SBC     = 6'd29,
    ACT_SEC     = 6'd30,
    ACT_SED     = 6'd31,
    ACT_SEI     = 6'd32,
    ACT_STA     = 6'd33,
    ACT_STX     = 6'd34,
    ACT_STY     = 6'd35,
    ACT_TAX     = 6'd36,
    ACT_TAY     = 6'd37,
    ACT_TSX     = 6'd38,
    ACT_TXA     = 6'd39,
    ACT_TXS     = 6'd40,
    ACT_TYA     = 6'd41,
    ACT_NOP     = 6'd42,
    ACT_BPL     = 6'd43,
    ACT_BMI     = 6'd44,
    ACT_BVC     = 6'd45,
    ACT_BVS     = 6'd46,
    ACT_BCC     = 6'd47,
    ACT_BCS     = 6'd48,
    ACT_BNE     = 6'd49,
    ACT_BEQ     = 6'd50,
    ACT_SLO     = 6'd51,
    ACT_RLA     = 6'd52,
    ACT_SRE     = 6'd53,
    ACT_RRA     = 6'd54,
    ACT_SAX     = 6'd55,
    ACT_LAX     = 6'd56,
    ACT_DCP     = 6'd57,
    ACT_ISC     = 6'd58,
    ACT_ASL_ACC = 6'd59,
    ACT_ROL_ACC = 6'd60,
    ACT_LSR_ACC = 6'd61,
    ACT_ROR_ACC = 6'd62
  } action_t;

  typedef enum logic [1:0] {
    STK_NONE = 2'd0,
    STK_PUSH = 2'd1,
    STK_PULL = 2'd2
  } stack_kind_t;

  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_ROL = 2'd1,
    SH_LSR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  // status bit positions, NV-BDIZC
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_B = 4;
  localparam int unsigned FL_U = 5;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0] RESET_SP    = 8'hfd;
  localparam logic [7:0] RESET_FLAGS = 8'h24;
  localparam logic [7:0] MASK_B      = 8'h10;
  localparam logic [7:0] MASK_U      = 8'h20;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] flags;
  } arch_state_t;

  typedef struct packed {
    logic [7:0]  write_data;
    logic        write_enable;
    logic        branch_taken;
    stack_kind_t stack_kind;
    logic [7:0]  stack_address;
  } exec_result_t;

endpackage
`default_nettype wire

@@ src/cpu6502_execute_unit.sv @@
// An accepted input transaction reaches m_tvalid through the input register, then the
//   result register.
// Throughput: one instruction per cycle unless m_tready stalls the result register;
//   the register file loop A/X/Y/SP/P closes through one pass of the execute logic.
// Reset (rst, synchronous): A=X=Y=0, SP=0xfd, P=0x24, both pipeline registers empty.
// Top level: 6502-style register and flag execution unit.
`default_nettype none
module cpu6502_execute_unit (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] operand
  input  wire [5:0]  s_tuser,   // [5:0] action
  output logic       m_tvalid,
  input  wire        m_tready,
  // [7:0] write_data, [8] write_enable, [9] branch_taken, [17:10] stack_address,
  // [25:18] acc_out, [33:26] x_out, [41:34] y_out, [49:42] flags_out, [55:50] zero
  output logic [55:0] m_tdata,
  output logic [1:0]  m_tuser   // [1:0] stack_kind
);

  logic                      in_valid;
  cpu6502_pkg::action_t      in_action;
  logic [7:0]                in_operand;
  logic                      advance;

  cpu6502_pkg::arch_state_t  state;
  cpu6502_pkg::arch_state_t  state_next;
  cpu6502_pkg::exec_result_t exec_res;

  logic                      out_valid;
  cpu6502_pkg::exec_result_t out_res;
  cpu6502_pkg::arch_state_t  out_state;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action  <= cpu6502_pkg::action_t'(s_tuser);
      in_operand <= s_tdata;
    end
  end

  cpu6502_alu u_alu (
    .action     (in_action),
    .operand    (in_operand),
    .state      (state),
    .state_next (state_next),
    .result     (exec_res)
  );

  cpu6502_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .commit     (advance),
    .state_next (state_next),
    .state      (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res   <= exec_res;
      out_state <= state_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_state.flags, out_state.y, out_state.x, out_state.acc,
                     out_res.stack_address, out_res.branch_taken, out_res.write_enable,
                     out_res.write_data};
  assign m_tuser  = out_res.stack_kind;

endmodule
`default_nettype wire

@@ src/cpu6502_regs.sv @@
// Architectural register file: A, X, Y, stack pointer and status byte.
`default_nettype none
module cpu6502_regs (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       commit,
  input  cpu6502_pkg::arch_state_t  state_next,
  output cpu6502_pkg::arch_state_t  state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state.acc   <= 8'h00;
      state.x     <= 8'h00;
      state.y     <= 8'h00;
      state.sp    <= cpu6502_pkg::RESET_SP;
      state.flags <= cpu6502_pkg::RESET_FLAGS;
    end else if (commit) begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ src/cpu6502_alu.sv @@
// Combinational execute logic: one instruction against the current registers.
`default_nettype none
module cpu6502_alu (
  input  cpu6502_pkg::action_t       action,
  input  wire [7:0]                  operand,
  input  cpu6502_pkg::arch_state_t   state,
  output cpu6502_pkg::arch_state_t   state_next,
  output cpu6502_pkg::exec_result_t  result
);

  // returns {carry, overflow, sum}
  function automatic logic [9:0] adc8(input logic [7:0] a, input logic [7:0] b,
                                      input logic cin);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    return {s[8], (s[7] ^ a[7]) & (s[7] ^ b[7]), s[7:0]};
  endfunction

  // returns {carry out, result}
  function automatic logic [8:0] shift8(input logic [7:0] v,
                                        input cpu6502_pkg::shift_kind_t kind,
                                        input logic cin);
    logic [8:0] r;
    unique case (kind)
      cpu6502_pkg::SH_ASL: r = {v[7], v[6:0], 1'b0};
      cpu6502_pkg::SH_ROL: r = {v[7], v[6:0], cin};
      cpu6502_pkg::SH_LSR: r = {v[0], 1'b0, v[7:1]};
      cpu6502_pkg::SH_ROR: r = {v[0], cin, v[7:1]};
      default:             r = {1'b0, v};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[cpu6502_pkg::FL_N] = v[7];
    q[cpu6502_pkg::FL_Z] = (v == 8'h00);
    return q;
  endfunction

  function automatic logic [7:0] with_cmp(input logic [7:0] p, input logic [7:0] r,
                                          input logic [7:0] v);
    logic [7:0] q;
    q = with_nz(p, r - v);
    q[cpu6502_pkg::FL_C] = (r >= v);
    return q;
  endfunction

  function automatic logic [7:0] with_add(input logic [7:0] p, input logic [9:0] s);
    logic [7:0] q;
    q = with_nz(p, s[7:0]);
    q[cpu6502_pkg::FL_C] = s[9];
    q[cpu6502_pkg::FL_V] = s[8];
    return q;
  endfunction

  always_comb begin
    logic [7:0] p;
    logic [7:0] a;
    logic       cin;
    logic [9:0] sum;
    logic [8:0] sh;
    logic [7:0] t;

    p   = state.flags;
    a   = state.acc;
    cin = p[cpu6502_pkg::FL_C];
    sum = 10'd0;
    sh  = 9'd0;
    t   = 8'd0;

    state_next = state;
    result.write_data    = 8'h00;
    result.write_enable  = 1'b0;
    result.branch_taken  = 1'b0;
    result.stack_kind    = cpu6502_pkg::STK_NONE;
    result.stack_address = 8'h00;

    unique case (action)
      cpu6502_pkg::ACT_ADC: begin
        sum = adc8(a, operand, cin);
        state_next.acc   = sum[7:0];
        state_next.flags = with_add(p, sum);
      end
      cpu6502_pkg::ACT_SBC: begin
        sum = adc8(a, ~operand, cin);
        state_next.acc   = sum[7:0];
        state_next.flags = with_add(p, sum);
      end
      cpu6502_pkg::ACT_AND: begin
        t = a & operand;
        state_next.acc   = t;
        state_next.flags = with_nz(p, t);
      end
      cpu6502_pkg::ACT_EOR: begin
        t = a ^ operand;
        state_next.acc   = t;
        state_next.flags = with_nz(p, t);
      end
      cpu6502_pkg::ACT_ORA: begin
        t = a | operand;
        state_next.acc   = t;
        state_next.flags = with_nz(p, t);
      end
      cpu6502_pkg::ACT_ASL, cpu6502_pkg::ACT_ROL,
      cpu6502_pkg::ACT_LSR, cpu6502_pkg::ACT_ROR: begin
        priority case (action)
          cpu6502_pkg::ACT_ASL: sh = shift8(operand, cpu6502_pkg::SH_ASL, cin);
          cpu6502_pkg::ACT_ROL: sh = shift8(operand, cpu6502_pkg::SH_ROL, cin);
          cpu6502_pkg::ACT_LSR: sh = shift8(operand, cpu6502_pkg::SH_LSR, cin);
          default:              sh = shift8(operand, cpu6502_pkg::SH_ROR, cin);
        endcase
        result.write_data   = sh[7:0];
        result.write_enable = 1'b1;
        state_next.flags    = with_nz(p, sh[7:0]);
        state_next.flags[cpu6502_pkg::FL_C] = sh[8];
      end
      cpu6502_pkg::ACT_ASL_ACC, cpu6502_pkg::ACT_ROL_ACC,
      cpu6502_pkg::ACT_LSR_ACC, cpu6502_pkg::ACT_ROR_ACC: begin
        priority case (action)
          cpu6502_pkg::ACT_ASL_ACC: sh = shift8(a, cpu6502_pkg::SH_ASL, cin);
          cpu6502_pkg::ACT_ROL_ACC: sh = shift8(a, cpu6502_pkg::SH_ROL, cin);
          cpu6502_pkg::ACT_LSR_ACC: sh = shift8(a, cpu6502_pkg::SH_LSR, cin);
          default:                  sh = shift8(a, cpu6502_pkg::SH_ROR, cin);
        endcase
        state_next.acc   = sh[7:0];
        state_next.flags = with_nz(p, sh[7:0]);
        state_next.flags[cpu6502_pkg::FL_C] = sh[8];
      end
      cpu6502_pkg::ACT_BIT: begin
        state_next.flags[cpu6502_pkg::FL_N] = operand[7];
        state_next.flags[cpu6502_pkg::FL_V] = operand[6];
        state_next.flags[cpu6502_pkg::FL_Z] = ((a & operand) == 8'h00);
      end
      cpu6502_pkg::ACT_CLC: state_next.flags[cpu6502_pkg::FL_C] = 1'b0;
      cpu6502_pkg::ACT_CLD: state_next.flags[cpu6502_pkg::FL_D] = 1'b0;
      cpu6502_pkg::ACT_CLI: state_next.flags[cpu6502_pkg::FL_I] = 1'b0;
      cpu6502_pkg::ACT_CLV: state_next.flags[cpu6502_pkg::FL_V] = 1'b0;
      cpu6502_pkg::ACT_SEC: state_next.flags[cpu6502_pkg::FL_C] = 1'b1;
      cpu6502_pkg::ACT_SED: state_next.flags[cpu6502_pkg::FL_D] = 1'b1;
      cpu6502_pkg::ACT_SEI: state_next.flags[cpu6502_pkg::FL_I] = 1'b1;
      cpu6502_pkg::ACT_CMP: state_next.flags = with_cmp(p, a, operand);
      cpu6502_pkg::ACT_CPX: state_next.flags = with_cmp(p, state.x, operand);
      cpu6502_pkg::ACT_CPY: state_next.flags = with_cmp(p, state.y, operand);
      cpu6502_pkg::ACT_DEC, cpu6502_pkg::ACT_INC: begin
        t = (action == cpu6502_pkg::ACT_DEC) ? operand - 8'd1 : operand + 8'd1;
        result.write_data   = t;
        result.write_enable = 1'b1;
        state_next.flags    = with_nz(p, t);
      end
      cpu6502_pkg::ACT_DEX: begin
        t = state.x - 8'd1;
        state_next.x     = t;
        state_next.flags = with_nz(p, t);
      end
      cpu6502_pkg::ACT_DEY: begin
        t = state.y - 8'd1;
        state_next.y     = t;
        state_next.flags = with_nz(p, t);
      end
      cpu6502_pkg::ACT_INX: begin
        t = state.x + 8'd1;
        state_next.x     = t;
        state_next.flags = with_nz(p, t);
      end
      cpu6502_pkg::ACT_INY: begin
        t = state.y + 8'd1;
        state_next.y     = t;
        state_next.flags = with_nz(p, t);
      end
      cpu6502_pkg::ACT_LDA: begin
        state_next.acc   = operand;
        state_next.flags = with_nz(p, operand);
      end
      cpu6502_pkg::ACT_LDX: begin
        state_next.x     = operand;
        state_next.flags = with_nz(p, operand);
      end
      cpu6502_pkg::ACT_LDY: begin
        state_next.y     = operand;
        state_next.flags = with_nz(p, operand);
      end
      cpu6502_pkg::ACT_PHA, cpu6502_pkg::ACT_PHP: begin
        // pushed status always carries B set
        result.write_data    = (action == cpu6502_pkg::ACT_PHA) ? a
                                                                : (p | cpu6502_pkg::MASK_B);
        result.write_enable  = 1'b1;
        result.stack_kind    = cpu6502_pkg::STK_PUSH;
        result.stack_address = state.sp;
        state_next.sp        = state.sp - 8'd1;
      end
      cpu6502_pkg::ACT_PLA: begin
        t = state.sp + 8'd1;
        result.stack_kind    = cpu6502_pkg::STK_PULL;
        result.stack_address = t;
        state_next.sp        = t;
        state_next.acc       = operand;
        state_next.flags     = with_nz(p, operand);
      end
      cpu6502_pkg::ACT_PLP: begin
        t = state.sp + 8'd1;
        result.stack_kind    = cpu6502_pkg::STK_PULL;
        result.stack_address = t;
        state_next.sp        = t;
        // B kept from current status, U forced
        state_next.flags     = (p & cpu6502_pkg::MASK_B) | (operand & ~cpu6502_pkg::MASK_B)
                               | cpu6502_pkg::MASK_U;
      end
      cpu6502_pkg::ACT_STA: begin
        result.write_data   = a;
        result.write_enable = 1'b1;
      end
      cpu6502_pkg::ACT_STX: begin
        result.write_data   = state.x;
        result.write_enable = 1'b1;
      end
      cpu6502_pkg::ACT_STY: begin
        result.write_data   = state.y;
        result.write_enable = 1'b1;
      end
      cpu6502_pkg::ACT_TAX: begin
        state_next.x     = a;
        state_next.flags = with_nz(p, a);
      end
      cpu6502_pkg::ACT_TAY: begin
        state_next.y     = a;
        state_next.flags = with_nz(p, a);
      end
      cpu6502_pkg::ACT_TSX: begin
        state_next.x     = state.sp;
        state_next.flags = with_nz(p, state.sp);
      end
      cpu6502_pkg::ACT_TXA: begin
        state_next.acc   = state.x;
        state_next.flags = with_nz(p, state.x);
      end
      cpu6502_pkg::ACT_TXS: state_next.sp = state.x;
      cpu6502_pkg::ACT_TYA: begin
        state_next.acc   = state.y;
        state_next.flags = with_nz(p, state.y);
      end
      cpu6502_pkg::ACT_NOP: ;
      cpu6502_pkg::ACT_BPL: result.branch_taken = ~p[cpu6502_pkg::FL_N];
      cpu6502_pkg::ACT_BMI: result.branch_taken =  p[cpu6502_pkg::FL_N];
      cpu6502_pkg::ACT_BVC: result.branch_taken = ~p[cpu6502_pkg::FL_V];
      cpu6502_pkg::ACT_BVS: result.branch_taken =  p[cpu6502_pkg::FL_V];
      cpu6502_pkg::ACT_BCC: result.branch_taken = ~p[cpu6502_pkg::FL_C];
      cpu6502_pkg::ACT_BCS: result.branch_taken =  p[cpu6502_pkg::FL_C];
      cpu6502_pkg::ACT_BNE: result.branch_taken = ~p[cpu6502_pkg::FL_Z];
      cpu6502_pkg::ACT_BEQ: result.branch_taken =  p[cpu6502_pkg::FL_Z];
      cpu6502_pkg::ACT_SLO, cpu6502_pkg::ACT_RLA,
      cpu6502_pkg::ACT_SRE, cpu6502_pkg::ACT_RRA: begin
        // shift memory, then combine with A; RRA adds using the shifted carry
        priority case (action)
          cpu6502_pkg::ACT_SLO: sh = shift8(operand, cpu6502_pkg::SH_ASL, cin);
          cpu6502_pkg::ACT_RLA: sh = shift8(operand, cpu6502_pkg::SH_ROL, cin);
          cpu6502_pkg::ACT_SRE: sh = shift8(operand, cpu6502_pkg::SH_LSR, cin);
          default:              sh = shift8(operand, cpu6502_pkg::SH_ROR, cin);
        endcase
        result.write_data   = sh[7:0];
        result.write_enable = 1'b1;
        priority case (action)
          cpu6502_pkg::ACT_SLO: t = a | sh[7:0];
          cpu6502_pkg::ACT_RLA: t = a & sh[7:0];
          cpu6502_pkg::ACT_SRE: t = a ^ sh[7:0];
          default: begin
            sum = adc8(a, sh[7:0], sh[8]);
            t   = sum[7:0];
          end
        endcase
        state_next.acc = t;
        if (action == cpu6502_pkg::ACT_RRA) begin
          state_next.flags = with_add(p, sum);
        end else begin
          state_next.flags = with_nz(p, t);
          state_next.flags[cpu6502_pkg::FL_C] = sh[8];
        end
      end
      cpu6502_pkg::ACT_SAX: begin
        result.write_data   = a & state.x;
        result.write_enable = 1'b1;
      end
      cpu6502_pkg::ACT_LAX: begin
        state_next.acc   = operand;
        state_next.x     = operand;
        state_next.flags = with_nz(p, operand);
      end
      cpu6502_pkg::ACT_DCP: begin
        t = operand - 8'd1;
        result.write_data   = t;
        result.write_enable = 1'b1;
        state_next.flags    = with_cmp(p, a, t);
      end
      cpu6502_pkg::ACT_ISC: begin
        t = operand + 8'd1;
        result.write_data   = t;
        result.write_enable = 1'b1;
        sum = adc8(a, ~t, cin);
        state_next.acc   = sum[7:0];
        state_next.flags = with_add(p, sum);
      end
      default: ; // unused selector behaves as NOP
    endcase
  end

endmodule
`default_nettype wire

@@ src/cpu6502_execute_unit_checker.sv @@
// Port-level checker for the execution unit, bound to the top level.
`default_nettype none
module cpu6502_execute_unit_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [55:0] m_tdata,
  input wire [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // no stack access means no address, and the kind is never the spare code
  a_stack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == cpu6502_pkg::STK_NONE) || (m_tuser == cpu6502_pkg::STK_PUSH)
                  || (m_tuser == cpu6502_pkg::STK_PULL))
                 && ((m_tuser != cpu6502_pkg::STK_NONE) || (m_tdata[17:10] == 8'h00)))
    else $error("bad stack kind or address");

  a_wd_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'h00)
    else $error("write data without strobe");

  // the unused status bit is always set
  a_flag_u: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47])
    else $error("status bit 5 clear");

endmodule

bind cpu6502_execute_unit cpu6502_execute_unit_checker u_checker (.*);
`default_nettype wire
